[rtl/core/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  // store geometry
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // fixed field widths
  localparam int VAL_W  = 32;
  localparam int ERR_W  = 2;
  localparam int FILL_W = 5;

  // action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // input beat
  typedef struct packed {
    logic                    action;
    logic signed [VAL_W-1:0] value;
  } spq_in_t;

  // result beat
  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic                    out_valid;
    logic [ERR_W-1:0]        error;
    logic [FILL_W-1:0]       fill_count;
  } spq_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } spq_cmd_t;

endpackage

`default_nettype wire

[rtl/core/sorted_insert_priority_queue.sv]
// a beat accepted by start while idle is latched, then run in the execute state; its result is registered
// a new beat is taken only while idle: busy is high during the controller's execute state after each load
// each execute cycle compares all cells of the store in parallel and, on a push, shifts cells up to insert
// the receiver cannot stall: out_strobe marks each result for exactly one cycle
// reset (rst_n low, synchronous) empties the store and clears control; contents undefined
`default_nettype none

module sorted_insert_priority_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire spq_pkg::spq_in_t  in_item,
  output logic                   out_strobe,
  output spq_pkg::spq_out_t      out_item
);

  spq_pkg::spq_cmd_t cmd;

  // sequencing
  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // sorted store and result registers
  spq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

[rtl/core/spq_ctrl.sv]
`default_nettype none

module spq_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  output spq_pkg::spq_cmd_t cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign busy     = (state_r == ST_EXEC);
  assign cmd.load = (state_r == ST_IDLE) && start;
  assign cmd.exec = (state_r == ST_EXEC);

endmodule

`default_nettype wire

[rtl/core/spq_datapath.sv]
`default_nettype none

module spq_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spq_pkg::spq_cmd_t cmd,
  input  wire spq_pkg::spq_in_t  in_item,
  output logic                   out_strobe,
  output spq_pkg::spq_out_t      out_item
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int CNT_W = spq_pkg::CNT_W;
  localparam int IDX_W = spq_pkg::IDX_W;
  localparam int VAL_W = spq_pkg::VAL_W;

  spq_pkg::spq_in_t        item_r;
  logic signed [VAL_W-1:0] entries_r   [DEPTH];
  logic signed [VAL_W-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_strobe_r;
  spq_pkg::spq_out_t       out_item_r;
  spq_pkg::spq_out_t       out_item_nxt;

  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] ge_prev;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;
  logic [IDX_W-1:0] pop_idx;

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
  end

  // per-cell compare: stored value at or below the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (entries_r[i] <= item_r.value);
    end
  end

  assign ge_prev = {ge[DEPTH-2:0], 1'b0};

  // per-cell insert: keep, take the new value, or shift up from below
  always_comb begin
    entries_nxt[0] = ge[0] ? entries_r[0] : item_r.value;
    for (int i = 1; i < DEPTH; i++) begin
      if (ge[i]) begin
        entries_nxt[i] = entries_r[i];
      end else if (ge_prev[i]) begin
        entries_nxt[i] = item_r.value;
      end else begin
        entries_nxt[i] = entries_r[i-1];
      end
    end
  end

  // operation decode
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = (item_r.action == spq_pkg::ACT_PUSH) && !full;
  assign do_pop  = (item_r.action == spq_pkg::ACT_POP) && !empty;
  assign pop_idx = IDX_W'(count_r - 1'b1);

  // next count and result
  always_comb begin
    count_nxt               = count_r;
    out_item_nxt.out_value  = '0;
    out_item_nxt.out_valid  = 1'b0;
    out_item_nxt.error      = spq_pkg::ERR_NONE;
    if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop) begin
      count_nxt              = count_r - 1'b1;
      out_item_nxt.out_value = entries_r[pop_idx];
      out_item_nxt.out_valid = 1'b1;
    end else if (item_r.action == spq_pkg::ACT_POP) begin
      out_item_nxt.error = spq_pkg::ERR_EMPTY;
    end else begin
      out_item_nxt.error = spq_pkg::ERR_FULL;
    end
    out_item_nxt.fill_count = spq_pkg::FILL_W'(count_nxt);
  end

  // store update
  always_ff @(posedge clk) begin
    if (cmd.exec && do_push) entries_r <= entries_nxt;
  end

  // fill count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.exec;
      if (cmd.exec) count_r <= count_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

[rtl/core/spq_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module spq_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire spq_pkg::spq_out_t out_item,
  input wire logic              out_strobe
);

  // an accepted beat keeps the block busy for the next cycle
  `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

  // every execute cycle ends in a result strobe
  `SPQ_ASSERT_NEXT(a_busy_strobe, busy, out_strobe, "busy cycle gave no result")

  // a popped value never carries an error
  `SPQ_ASSERT_NOW(a_valid_noerr, out_strobe && out_item.out_valid,
    out_item.error == spq_pkg::ERR_NONE, "valid pop flagged an error")

  // overflow only when the store is full
  `SPQ_ASSERT_NOW(a_full_count, out_strobe && out_item.error == spq_pkg::ERR_FULL,
    out_item.fill_count == spq_pkg::FILL_W'(spq_pkg::DEPTH), "overflow below full")

  // fill count stays within depth
  `SPQ_ASSERT_NOW(a_fill_range, out_strobe,
    out_item.fill_count <= spq_pkg::FILL_W'(spq_pkg::DEPTH), "fill count above depth")

endmodule

bind sorted_insert_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_item   (out_item),
  .out_strobe (out_strobe)
);

`default_nettype wire
